/* rtl/omst_pkg.sv */
package omst_pkg;

	localparam int SLOTS  = 16;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam int KIND_W   = 8;
	localparam int PORT_W   = 16;
	localparam int HANDLE_W = 16;
	localparam int STAMP_W  = 32;
	localparam int STAT_W   = 2;
	localparam int SLOTF_W  = 4;

	localparam int IN_W  = 48;
	localparam int OUT_W = 24;

	// request opcodes
	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
	localparam logic [STAT_W-1:0] ST_NONE = 2'd2;

	// scan token handed from cell to cell
	typedef struct packed {
		logic                vld;
		logic                found;
		logic [SLOT_W-1:0]   pos;
		logic [STAMP_W-1:0]  best;
		logic [PORT_W-1:0]   port;
	} tok_t;

	// request fields broadcast to all cells during a scan
	typedef struct packed {
		logic              op;
		logic [KIND_W-1:0] kind;
	} req_t;

	// table update broadcast at the end of a scan
	typedef struct packed {
		logic                set;
		logic                clr;
		logic [SLOT_W-1:0]   pos;
		logic [KIND_W-1:0]   kind;
		logic [PORT_W-1:0]   port;
		logic [HANDLE_W-1:0] handle;
		logic [STAMP_W-1:0]  stamp;
	} cmt_t;

	typedef struct packed {
		logic [PORT_W-1:0]  port;
		logic [SLOTF_W-1:0] slot;
		logic [STAT_W-1:0]  status;
	} res_t;

endpackage

/* rtl/omst_cell.sv */
// One table slot plus one stage of the scan chain.
module omst_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [omst_pkg::SLOT_W-1:0]   idx,
	input  omst_pkg::req_t                req,
	input  omst_pkg::cmt_t                cmt,
	input  omst_pkg::tok_t                tok_in,
	output omst_pkg::tok_t                tok_out
);

	logic                              valid_q;
	logic [omst_pkg::KIND_W-1:0]       task_q;
	logic [omst_pkg::PORT_W-1:0]       port_q;
	logic [omst_pkg::HANDLE_W-1:0]     handle_q;
	logic [omst_pkg::STAMP_W-1:0]      age_q;

	logic                              tok_vld_q;
	omst_pkg::tok_t                    tok_nxt;
	omst_pkg::tok_t                    tok_dat_q;
	logic                              hit;

	always_comb begin
		tok_nxt = tok_in;
		hit     = 1'b0;
		if (req.op == omst_pkg::OP_ADD) begin
			hit = !tok_in.found && !valid_q;
		end else begin
			hit = valid_q && (task_q == req.kind) &&
			      (!tok_in.found || ($signed(age_q) < $signed(tok_in.best)));
		end
		if (hit) begin
			tok_nxt.found = 1'b1;
			tok_nxt.pos   = idx;
			tok_nxt.best  = age_q;
			tok_nxt.port  = port_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_in.vld;
			if (cmt.set && cmt.pos == idx) begin
				valid_q <= 1'b1;
			end else if (cmt.clr && cmt.pos == idx) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_dat_q <= tok_nxt;
		if (cmt.set && cmt.pos == idx) begin
			task_q   <= cmt.kind;
			port_q   <= cmt.port;
			handle_q <= cmt.handle;
			age_q    <= cmt.stamp;
		end
	end

	always_comb begin
		tok_out     = tok_dat_q;
		tok_out.vld = tok_vld_q;
	end

endmodule

/* rtl/oldest_match_slot_table.sv */
// Slot table with oldest-match removal.
//
// Input stream (s_axis_*): one request per accepted item. operation 0 adds
// an entry (task_kind, src_port, client_handle) to the lowest free slot
// and stamps it; operation 1 frees the valid slot of task_kind whose stamp
// is oldest (signed 32-bit order, lowest slot on a tie).
// Output stream (m_axis_*): exactly one result per request: status, slot
// and entry_port, with slot and entry_port zero unless status is done.
//
// Timing: a request walks a chain of SLOTS cells, one cell per cycle, then
// the table is updated and the result registered. A new request is taken
// only once the scan has ended and the hold register is empty, so requests
// never overlap and throughput is set by the length of the cell chain.
// Reset (arst_n low) frees every slot, clears the stamp counter and drops
// any request in flight. If the receiver stalls, a finished result waits in
// the output register and a second one in a hold register; requests are
// refused during a scan and while the hold register is full.
module oldest_match_slot_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// [0] operation, [8:1] task_kind, [24:9] src_port,
	// [40:25] client_handle, [47:41] zero
	input  logic [omst_pkg::IN_W-1:0]   s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// [1:0] status, [5:2] slot, [21:6] entry_port, [23:22] zero
	output logic [omst_pkg::OUT_W-1:0]  m_axis_tdata
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic                             state_q;
	logic                             s_acc;
	logic                             m_acc;

	// held request
	logic                             op_q;
	logic [omst_pkg::KIND_W-1:0]      kind_q;
	logic [omst_pkg::PORT_W-1:0]      port_q;
	logic [omst_pkg::HANDLE_W-1:0]    handle_q;
	logic [omst_pkg::STAMP_W-1:0]     stamp_q;

	omst_pkg::req_t                   req;
	omst_pkg::cmt_t                   cmt;
	omst_pkg::tok_t                   tok_head;
	omst_pkg::tok_t                   tok [omst_pkg::SLOTS];
	omst_pkg::tok_t                   tail;
	omst_pkg::res_t                   res;

	// output register and hold stage
	omst_pkg::res_t                   out_q;
	logic                             out_vld_q;
	omst_pkg::res_t                   hold_q;
	logic                             hold_vld_q;
	logic                             done;

	assign s_axis_tready = (state_q == ST_IDLE) && !hold_vld_q;
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign m_acc         = out_vld_q && m_axis_tready;

	assign req.op   = op_q;
	assign req.kind = kind_q;

	// token enters cell 0 at the accept edge; its fields start at zero
	always_comb begin
		tok_head       = '0;
		tok_head.vld   = s_acc;
	end

	// cell 0 must see the new request in the accept cycle
	omst_pkg::req_t req_c0;
	assign req_c0.op   = s_acc ? s_axis_tdata[0]   : op_q;
	assign req_c0.kind = s_acc ? s_axis_tdata[8:1] : kind_q;

	genvar gi;
	generate
		for (gi = 0; gi < omst_pkg::SLOTS; gi++) begin : g_cell
			if (gi == 0) begin : g_first
				omst_cell u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.idx     (omst_pkg::SLOT_W'(gi)),
					.req     (req_c0),
					.cmt     (cmt),
					.tok_in  (tok_head),
					.tok_out (tok[gi])
				);
			end else begin : g_rest
				omst_cell u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.idx     (omst_pkg::SLOT_W'(gi)),
					.req     (req),
					.cmt     (cmt),
					.tok_in  (tok[gi-1]),
					.tok_out (tok[gi])
				);
			end
		end
	endgenerate

	assign tail = tok[omst_pkg::SLOTS-1];
	assign done = tail.vld && (state_q == ST_SCAN);

	// resolve the scan: table update and result
	always_comb begin
		cmt        = '0;
		cmt.pos    = tail.pos;
		cmt.kind   = kind_q;
		cmt.port   = port_q;
		cmt.handle = handle_q;
		cmt.stamp  = stamp_q;
		res        = '0;
		if (op_q == omst_pkg::OP_ADD) begin
			if (tail.found) begin
				cmt.set    = done;
				res.status = omst_pkg::ST_DONE;
				res.slot   = omst_pkg::SLOTF_W'(tail.pos);
				res.port   = port_q;
			end else begin
				res.status = omst_pkg::ST_FULL;
			end
		end else begin
			if (tail.found) begin
				cmt.clr    = done;
				res.status = omst_pkg::ST_DONE;
				res.slot   = omst_pkg::SLOTF_W'(tail.pos);
				res.port   = tail.port;
			end else begin
				res.status = omst_pkg::ST_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			stamp_q    <= '0;
			out_vld_q  <= 1'b0;
			hold_vld_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmt.set) begin
				stamp_q <= stamp_q + 1'b1;
			end
			// hold is only ever filled while the output is stalled
			if (done && out_vld_q && !m_acc) begin
				hold_vld_q <= 1'b1;
			end else if (m_acc) begin
				hold_vld_q <= 1'b0;
			end
			if (done || (m_acc && hold_vld_q)) begin
				out_vld_q <= 1'b1;
			end else if (m_acc) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_q     <= s_axis_tdata[0];
			kind_q   <= s_axis_tdata[8:1];
			port_q   <= s_axis_tdata[24:9];
			handle_q <= s_axis_tdata[40:25];
		end
		if (done && out_vld_q && !m_acc) begin
			hold_q <= res;
		end
		if (m_acc && hold_vld_q) begin
			out_q <= hold_q;
		end else if (done && (!out_vld_q || m_acc)) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {2'b00, out_q.port, out_q.slot, out_q.status};

endmodule

/* rtl/omst_check.sv */
module omst_check (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic [omst_pkg::IN_W-1:0]   s_axis_tdata,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [omst_pkg::OUT_W-1:0]  m_axis_tdata
);

	// one request at a time: no back-to-back accepts
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("request accepted while scan busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("result dropped under stall");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[1:0] == omst_pkg::ST_DONE ||
		                   m_axis_tdata[1:0] == omst_pkg::ST_FULL ||
		                   m_axis_tdata[1:0] == omst_pkg::ST_NONE))
		else $error("bad status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[1:0] != omst_pkg::ST_DONE) |->
		(m_axis_tdata[21:2] == 20'd0))
		else $error("slot or port nonzero on failed request");

endmodule

bind oldest_match_slot_table omst_check u_omst_check (.*);

/* dv/tb_oldest_match_slot_table.sv */
module tb_oldest_match_slot_table;
	import omst_pkg::*;

	// cycles with no request or result moving before the run is called hung;
	// the limit allows for a whole scan per request plus a long receiver stall
	localparam int STALL_LIMIT = 2000;
	localparam int PAD_W = IN_W - 1 - KIND_W - PORT_W - HANDLE_W;

	logic               clk;
	logic               arst_n;
	logic               s_valid;
	logic               s_ready;
	logic [IN_W-1:0]    s_data;
	logic               m_valid;
	logic               m_ready;
	logic [OUT_W-1:0]   m_data;

	// shadow copy of the slot table
	logic                tbl_valid  [SLOTS];
	logic [KIND_W-1:0]   tbl_kind   [SLOTS];
	logic [PORT_W-1:0]   tbl_port   [SLOTS];
	logic [HANDLE_W-1:0] tbl_handle [SLOTS];
	logic [STAMP_W-1:0]  tbl_stamp  [SLOTS];
	logic [STAMP_W-1:0]  stamp_next;

	res_t outcome_q [$];

	int errors;
	int stall_cycles;
	int n_added;
	int n_refused;
	int n_freed;
	int n_absent;
	int send_idle_pct;
	int recv_idle_pct;

	oldest_match_slot_table u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Apply one request to the shadow table and return the result it must give.
	// Stamps are unique within this run (the counter cannot wrap in ~1k adds),
	// so the tie rule never fires; the compare is signed as the block defines.
	function automatic res_t apply_request(input logic op, input logic [KIND_W-1:0] kind,
			input logic [PORT_W-1:0] port, input logic [HANDLE_W-1:0] handle);
		res_t r;
		int   pos;
		int   i;
		bit   hit;
		r   = '0;
		pos = 0;
		hit = 1'b0;
		if (op == OP_ADD) begin
			for (i = 0; i < SLOTS; i++)
				if (!hit && !tbl_valid[i]) begin
					pos = i;
					hit = 1'b1;
				end
			if (!hit) begin
				r.status = ST_FULL;
				n_refused++;
			end else begin
				tbl_valid[pos]  = 1'b1;
				tbl_kind[pos]   = kind;
				tbl_port[pos]   = port;
				tbl_handle[pos] = handle;
				tbl_stamp[pos]  = stamp_next;
				stamp_next      = stamp_next + 1'b1;
				r.status = ST_DONE;
				r.slot   = pos[SLOTF_W-1:0];
				r.port   = port;
				n_added++;
			end
		end else begin
			for (i = 0; i < SLOTS; i++)
				if (tbl_valid[i] && tbl_kind[i] == kind &&
						(!hit || $signed(tbl_stamp[i]) < $signed(tbl_stamp[pos]))) begin
					pos = i;
					hit = 1'b1;
				end
			if (!hit) begin
				r.status = ST_NONE;
				n_absent++;
			end else begin
				tbl_valid[pos] = 1'b0;
				r.status = ST_DONE;
				r.slot   = pos[SLOTF_W-1:0];
				r.port   = tbl_port[pos];
				n_freed++;
			end
		end
		return r;
	endfunction

	// Drive one request; random idle cycles go ahead of it. Valid stays high
	// into the next call when no gap is drawn.
	task automatic send_request(input logic op, input logic [KIND_W-1:0] kind,
			input logic [PORT_W-1:0] port, input logic [HANDLE_W-1:0] handle);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			s_valid <= 1'b0;
		end
		@(negedge clk);
		s_valid <= 1'b1;
		s_data  <= {{PAD_W{1'b0}}, handle, port, kind, op};
		do @(posedge clk); while (!s_ready);
		outcome_q.push_back(apply_request(op, kind, port, handle));
	endtask

	// Sender holds off until every outstanding result is back.
	task automatic drain_results();
		@(negedge clk);
		s_valid <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
	endtask

	// Empty-table remove, fill to the last slot with the field extremes,
	// then one add that must be refused.
	task automatic test_fill_to_full();
		int i;
		logic [KIND_W-1:0]   kind;
		logic [PORT_W-1:0]   port;
		logic [HANDLE_W-1:0] handle;
		send_request(OP_REMOVE, 8'h00, 16'h1234, 16'h4321);
		for (i = 0; i < SLOTS; i++) begin
			kind   = (i % 3 == 0) ? 8'hFF : (i % 3 == 1) ? 8'h00 : 8'h5A;
			port   = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'($urandom_range(16'hFFFF));
			handle = (i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : 16'($urandom_range(16'hFFFF));
			send_request(OP_ADD, kind, port, handle);
		end
		send_request(OP_ADD, 8'h11, 16'hFFFF, 16'hFFFF);
	endtask

	// Oldest-by-stamp removal, miss on a full table, reuse of the lowest freed
	// slot, and a refilled low slot that must not win over an older high one.
	task automatic test_oldest_removal();
		send_request(OP_REMOVE, 8'h33, 16'h0000, 16'h0000);
		send_request(OP_REMOVE, 8'hFF, 16'h0000, 16'h0000);
		send_request(OP_REMOVE, 8'hFF, 16'h0000, 16'h0000);
		send_request(OP_ADD,    8'h33, 16'hA5A5, 16'h5A5A);
		send_request(OP_REMOVE, 8'h00, 16'h0000, 16'h0000);
		send_request(OP_REMOVE, 8'h33, 16'h0000, 16'h0000);
		send_request(OP_ADD,    8'hFF, 16'h0F0F, 16'hF0F0);
		send_request(OP_REMOVE, 8'hFF, 16'h0000, 16'h0000);
	endtask

	// Bursts alternate between add-heavy and remove-heavy so occupancy swings
	// between empty and full; most kinds come from a small pool so removes hit.
	task automatic test_random_traffic(input int count);
		int k;
		int add_pct;
		logic [KIND_W-1:0] kind_pool [4];
		logic              op;
		logic [KIND_W-1:0] kind;
		for (k = 0; k < 4; k++)
			kind_pool[k] = 8'($urandom_range(255));
		add_pct = 75;
		for (k = 0; k < count; k++) begin
			if (k % 40 == 0)
				add_pct = (add_pct == 75) ? 25 : 75;
			if (k == count / 2)
				drain_results();
			op   = ($urandom_range(99) < add_pct) ? OP_ADD : OP_REMOVE;
			kind = ($urandom_range(9) < 8) ? kind_pool[$urandom_range(3)]
			                               : 8'($urandom_range(255));
			send_request(op, kind, 16'($urandom_range(16'hFFFF)),
			             16'($urandom_range(16'hFFFF)));
		end
	endtask

	// receiver back-pressure
	always @(negedge clk)
		m_ready <= ($urandom_range(99) >= recv_idle_pct);

	// result checker
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && m_valid && m_ready) begin
			got = res_t'(m_data[$bits(res_t)-1:0]);
			if (outcome_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_data);
				errors++;
			end else begin
				want = outcome_q.pop_front();
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
					errors++;
				end
				if (got.slot !== want.slot) begin
					$display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
					errors++;
				end
				if (got.port !== want.port) begin
					$display("%0t: entry_port expected %h actual %h", $time, want.port, got.port);
					errors++;
				end
			end
		end
	end

	// hang detector
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_valid && s_ready) || (m_valid && m_ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
					$display("tb_oldest_match_slot_table failed");
					$finish;
				end
			end
		end
	end

	initial begin
		int i;
		arst_n        = 1'b0;
		s_valid       = 1'b0;
		s_data        = '0;
		m_ready       = 1'b0;
		errors        = 0;
		stall_cycles  = 0;
		n_added       = 0;
		n_refused     = 0;
		n_freed       = 0;
		n_absent      = 0;
		stamp_next    = '0;
		send_idle_pct = 17;
		recv_idle_pct = 80;
		for (i = 0; i < SLOTS; i++) begin
			tbl_valid[i]  = 1'b0;
			tbl_kind[i]   = '0;
			tbl_port[i]   = '0;
			tbl_handle[i] = '0;
			tbl_stamp[i]  = '0;
		end
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_fill_to_full();
		test_oldest_removal();
		test_random_traffic(380);

		send_idle_pct = 80;
		recv_idle_pct = 17;
		test_random_traffic(380);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(390);

		drain_results();
		repeat (40) @(posedge clk);

		$display("covered %0d adds, %0d refused as full, %0d removals, %0d missed removals",
		         n_added, n_refused, n_freed, n_absent);
		$display("traffic ran with sender gaps, receiver stalls, and at full rate");
		if (errors == 0)
			$display("tb_oldest_match_slot_table passed");
		else
			$display("tb_oldest_match_slot_table failed");
		$finish;
	end

endmodule

/* oldest_match_slot_table.f */
rtl/omst_pkg.sv
rtl/omst_cell.sv
rtl/oldest_match_slot_table.sv
rtl/omst_check.sv
dv/tb_oldest_match_slot_table.sv
